>>> src/dle_frame_receiver_with_checksum_unit_defines.svh
// Assertion macros used by the property checker module dlefr_props.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef DLE_FRAME_RECEIVER_WITH_CHECKSUM_UNIT_DEFINES_SVH
`define DLE_FRAME_RECEIVER_WITH_CHECKSUM_UNIT_DEFINES_SVH

// Same-cycle implication.
`define DLE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define DLE_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

>>> src/dlefr_pkg.sv
package dlefr_pkg;

   localparam int BYTE_W     = 8;
   localparam int SUM_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // output queue depth, power of two, at least 2
   localparam int RSP_FIFO_DEPTH = 4;

   localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd30;
   localparam logic [BYTE_W-1:0] MIN_LEN       = 8'd2;

   localparam logic CSR_IDX_MAX_FRAME_LEN = 1'b0;

   localparam logic REQ_TIMEOUT = 1'b1;

   localparam logic [BYTE_W-1:0] DLE = 8'h10;
   localparam logic [BYTE_W-1:0] STX = 8'h02;
   localparam logic [BYTE_W-1:0] ETX = 8'h03;

   localparam logic [STATUS_W-1:0] ST_IN_PROGRESS = 3'd0;
   localparam logic [STATUS_W-1:0] ST_GOOD        = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD         = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT     = 3'd4;

   typedef struct packed {
      logic                byte_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                frame_last;
      logic [STATUS_W-1:0] frame_status;
      logic [SUM_W-1:0]    sum_value;
   } res_type;

   // up to two results per request
   typedef struct packed {
      logic [1:0] num;
      res_type    r0;
      res_type    r1;
   } push_type;

endpackage

>>> src/dlefr_req_if.sv
interface dlefr_req_if import dlefr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output req_type, output rx_byte, input ready);
   modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

>>> src/dlefr_rsp_if.sv
interface dlefr_rsp_if import dlefr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                byte_valid;
   logic [BYTE_W-1:0]   out_byte;
   logic                frame_last;
   logic [STATUS_W-1:0] frame_status;
   logic [SUM_W-1:0]    sum_value;

   modport source (output valid, output byte_valid, output out_byte, output frame_last,
                   output frame_status, output sum_value, input ready);
   modport sink   (input valid, input byte_valid, input out_byte, input frame_last,
                   input frame_status, input sum_value, output ready);
endinterface

>>> src/dlefr_csr.sv
module dlefr_csr import dlefr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [BYTE_W-1:0]     max_len
);

   logic [BYTE_W-1:0] max_len_ff;
   logic [BYTE_W-1:0] max_len_in;
   logic              hit;

   assign hit    = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_MAX_FRAME_LEN);
   assign pready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (psel && penable && pwrite && hit) begin
         max_len_in = pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   assign prdata  = hit ? {{(CSR_DATA_W-BYTE_W){1'b0}}, max_len_ff} : '0;
   assign max_len = max_len_ff;

endmodule

>>> src/dlefr_core.sv
module dlefr_core import dlefr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              req_type,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [BYTE_W-1:0] max_len,
   output push_type          push
);

   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_GOT10   = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_ESC     = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] r0_ff, r0_in, r1_ff, r1_in, r2_ff, r2_in;

   logic [BYTE_W-1:0] lim;
   logic [BYTE_W-1:0] stored_count;
   logic [SUM_W-1:0]  stored_sum;
   logic              clear_frame;

   assign lim          = (max_len < MIN_LEN) ? MIN_LEN : max_len;
   assign stored_count = count_ff + 8'd1;
   assign stored_sum   = sum_ff + {{(SUM_W-BYTE_W){1'b0}}, r2_ff};

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      r0_in       = r0_ff;
      r1_in       = r1_ff;
      r2_in       = r2_ff;
      clear_frame = 1'b0;
      push        = '0;

      if (accept) begin
         if (req_type == REQ_TIMEOUT) begin
            push.num             = 2'd1;
            push.r0.frame_last   = 1'b1;
            push.r0.frame_status = ST_TIMEOUT;
            clear_frame          = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
                  if (rx_byte == DLE) begin
                     phase_in = PH_GOT10;
                     count_in = 8'd1;
                  end
               end
               PH_GOT10: begin
                  if (rx_byte == STX) begin
                     // restart the frame with both opening bytes stored
                     push.num           = 2'd2;
                     push.r0.byte_valid = 1'b1;
                     push.r0.out_byte   = DLE;
                     push.r1.byte_valid = 1'b1;
                     push.r1.out_byte   = STX;
                     sum_in             = '0;
                     r2_in              = '0;
                     r1_in              = DLE;
                     r0_in              = STX;
                     count_in           = MIN_LEN;
                     if (MIN_LEN >= lim) begin
                        push.r1.frame_last   = 1'b1;
                        push.r1.frame_status = ST_OVERFLOW;
                        clear_frame          = 1'b1;
                     end else begin
                        phase_in = PH_PAYLOAD;
                     end
                  end else if (rx_byte != DLE) begin
                     clear_frame = 1'b1;
                  end
               end
               PH_PAYLOAD: begin
                  push.num           = 2'd1;
                  push.r0.byte_valid = 1'b1;
                  push.r0.out_byte   = rx_byte;
                  sum_in             = stored_sum;
                  r2_in              = r1_ff;
                  r1_in              = r0_ff;
                  r0_in              = rx_byte;
                  count_in           = stored_count;
                  if (stored_count >= lim) begin
                     push.r0.frame_last   = 1'b1;
                     push.r0.frame_status = ST_OVERFLOW;
                     clear_frame          = 1'b1;
                  end else if (rx_byte == DLE) begin
                     phase_in = PH_ESC;
                  end
               end
               PH_ESC: begin
                  if (rx_byte == ETX) begin
                     push.num             = 2'd1;
                     push.r0.byte_valid   = 1'b1;
                     push.r0.out_byte     = ETX;
                     push.r0.frame_last   = 1'b1;
                     push.r0.frame_status = (sum_ff == {r2_ff, r1_ff}) ? ST_GOOD : ST_BAD;
                     push.r0.sum_value    = sum_ff;
                     clear_frame          = 1'b1;
                  end else begin
                     // drop the stuffing byte
                     phase_in = PH_PAYLOAD;
                  end
               end
            endcase
         end
      end

      if (clear_frame) begin
         phase_in = PH_HUNT;
         count_in = '0;
         sum_in   = '0;
         r0_in    = '0;
         r1_in    = '0;
         r2_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         sum_ff   <= '0;
         r0_ff    <= '0;
         r1_ff    <= '0;
         r2_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         r0_ff    <= r0_in;
         r1_ff    <= r1_in;
         r2_ff    <= r2_in;
      end
   end

endmodule

>>> src/dlefr_rsp_fifo.sv
module dlefr_rsp_fifo import dlefr_pkg::*; #(
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output logic     head_valid,
   output res_type  head,
   output logic     room
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   res_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign head_valid  = (count_ff != '0);
   assign head        = mem_ff[rd_ptr_ff];
   // a request may push two results
   assign room        = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.num);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push.num) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.num == 2'd2) begin
         mem_ff[wr_ptr_next] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> src/dle_frame_receiver_with_checksum_unit.sv
// Results of a request are written into the output queue when it is accepted.
// Throughput: one request per cycle while ready is high; the frame decode is a
// single compare/add step. An opening 0x02 pushes two results; ready drops while
// the output queue has fewer than two free slots.
// Reset (synchronous, active high) clears the frame state and the output queue,
// and sets max_frame_len to 30.
module dle_frame_receiver_with_checksum_unit import dlefr_pkg::*; #(
   parameter int RSP_DEPTH = RSP_FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   dlefr_req_if.sink             req,
   dlefr_rsp_if.source           rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BYTE_W-1:0] max_len;
   logic              accept;
   logic              room;
   push_type          push;
   res_type           head;

   assign req.ready = room;
   assign accept    = req.valid && room;

   dlefr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .max_len (max_len)
   );

   dlefr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_type (req.req_type),
      .rx_byte  (req.rx_byte),
      .max_len  (max_len),
      .push     (push)
   );

   dlefr_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp.valid && rsp.ready),
      .head_valid (rsp.valid),
      .head       (head),
      .room       (room)
   );

   assign rsp.byte_valid   = head.byte_valid;
   assign rsp.out_byte     = head.out_byte;
   assign rsp.frame_last   = head.frame_last;
   assign rsp.frame_status = head.frame_status;
   assign rsp.sum_value    = head.sum_value;

endmodule

>>> src/dlefr_checker.sv
`include "dle_frame_receiver_with_checksum_unit_defines.svh"

module dlefr_props import dlefr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_type,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_byte_valid,
   input logic [BYTE_W-1:0]   rsp_out_byte,
   input logic                rsp_frame_last,
   input logic [STATUS_W-1:0] rsp_frame_status,
   input logic [SUM_W-1:0]    rsp_sum_value
);

   logic    rsp_stall;
   logic    req_timeout;
   logic    rsp_verdict;
   logic    rsp_etx_end;
   logic    rsp_mid_ok;
   res_type rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_timeout = req_valid && req_ready && (req_type == REQ_TIMEOUT);
   assign rsp_verdict = rsp_valid && ((rsp_frame_status == ST_GOOD) ||
                                      (rsp_frame_status == ST_BAD));
   assign rsp_etx_end = rsp_byte_valid && rsp_frame_last && (rsp_out_byte == ETX);
   assign rsp_mid_ok  = rsp_byte_valid && (rsp_frame_status == ST_IN_PROGRESS) &&
                        (rsp_sum_value == '0);
   assign rsp_payload = {rsp_byte_valid, rsp_out_byte, rsp_frame_last, rsp_frame_status,
                         rsp_sum_value};

   // stalled response holds
   `DLE_ASSERT_NXT(chk_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload))

   // after a timeout is accepted, a response is always valid on the next cycle
   `DLE_ASSERT_NXT(chk_timeout_rsp, req_timeout, rsp_valid)

   // checksum verdict only on the closing byte
   `DLE_ASSERT_IMP(chk_verdict_on_etx, rsp_verdict, rsp_etx_end)

   // mid-frame results carry a byte, no status and no sum
   `DLE_ASSERT_IMP(chk_mid_frame, rsp_valid && !rsp_frame_last, rsp_mid_ok)

endmodule

bind dle_frame_receiver_with_checksum_unit dlefr_props u_dlefr_props (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .req_type         (req.req_type),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_byte_valid   (rsp.byte_valid),
   .rsp_out_byte     (rsp.out_byte),
   .rsp_frame_last   (rsp.frame_last),
   .rsp_frame_status (rsp.frame_status),
   .rsp_sum_value    (rsp.sum_value)
);

>>> tb/dlefr_checker.sv
`timescale 1ns / 1ps

module dlefr_checker import dlefr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_type,
   input  logic [BYTE_W-1:0]     rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  byte_valid,
   input  logic [BYTE_W-1:0]     out_byte,
   input  logic                  frame_last,
   input  logic [STATUS_W-1:0]   frame_status,
   input  logic [SUM_W-1:0]      sum_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    results_seen,
   output int                    n_good,
   output int                    n_bad,
   output int                    n_overflow,
   output int                    n_timeout
);

   localparam logic [CSR_ADDR_W-1:0] LEN_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MAX_FRAME_LEN);

   typedef enum logic [1:0] {HUNTING, GOT_DLE, IN_FRAME, AFTER_DLE} rx_phase_type;

   logic [BYTE_W-1:0] len_limit;
   rx_phase_type      rx_phase;
   logic [BYTE_W-1:0] stored_cnt;
   logic [SUM_W-1:0]  frame_sum;
   logic [BYTE_W-1:0] last_bytes [0:2];
   res_type           deframed_q [$];
   int                fails, results, goods, bads, overflows, timeouts;

   function automatic res_type make_res(input logic v, input logic [BYTE_W-1:0] b,
                                        input logic last, input logic [STATUS_W-1:0] st,
                                        input logic [SUM_W-1:0] s);
      res_type r;
      r.byte_valid   = v;
      r.out_byte     = b;
      r.frame_last   = last;
      r.frame_status = st;
      r.sum_value    = s;
      return r;
   endfunction

   function automatic void clear_frame();
      rx_phase   = HUNTING;
      stored_cnt = '0;
      frame_sum  = '0;
      last_bytes = '{default: '0};
   endfunction

   // the sum trails the stored stream by three bytes
   function automatic void store_byte(input logic [BYTE_W-1:0] b);
      frame_sum     = frame_sum + SUM_W'(last_bytes[2]);
      last_bytes[2] = last_bytes[1];
      last_bytes[1] = last_bytes[0];
      last_bytes[0] = b;
      stored_cnt    = stored_cnt + BYTE_W'(1);
   endfunction

   function automatic logic limit_hit();
      logic [BYTE_W-1:0] lim;
      lim = (len_limit < MIN_LEN) ? MIN_LEN : len_limit;
      return stored_cnt >= lim;
   endfunction

   function automatic void deframe_step(input logic rtype, input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] want;
      if (rtype == REQ_TIMEOUT) begin
         deframed_q.push_back(make_res(1'b0, '0, 1'b1, ST_TIMEOUT, '0));
         clear_frame();
      end else begin
         case (rx_phase)
            HUNTING: begin
               if (b == DLE) begin
                  rx_phase   = GOT_DLE;
                  stored_cnt = 8'd1;
               end
            end
            GOT_DLE: begin
               if (b == STX) begin
                  frame_sum  = '0;
                  last_bytes = '{default: '0};
                  stored_cnt = '0;
                  store_byte(DLE);
                  store_byte(STX);
                  deframed_q.push_back(make_res(1'b1, DLE, 1'b0, ST_IN_PROGRESS, '0));
                  if (limit_hit()) begin
                     deframed_q.push_back(make_res(1'b1, STX, 1'b1, ST_OVERFLOW, '0));
                     clear_frame();
                  end else begin
                     deframed_q.push_back(make_res(1'b1, STX, 1'b0, ST_IN_PROGRESS, '0));
                     rx_phase = IN_FRAME;
                  end
               end else if (b != DLE) begin
                  clear_frame();
               end
            end
            IN_FRAME: begin
               store_byte(b);
               if (limit_hit()) begin
                  deframed_q.push_back(make_res(1'b1, b, 1'b1, ST_OVERFLOW, '0));
                  clear_frame();
               end else begin
                  deframed_q.push_back(make_res(1'b1, b, 1'b0, ST_IN_PROGRESS, '0));
                  if (b == DLE) rx_phase = AFTER_DLE;
               end
            end
            default: begin
               if (b == ETX) begin
                  want = {last_bytes[2], last_bytes[1]};
                  deframed_q.push_back(make_res(1'b1, b, 1'b1,
                                                (frame_sum == want) ? ST_GOOD : ST_BAD,
                                                frame_sum));
                  clear_frame();
               end else begin
                  // drop the stuffing byte
                  rx_phase = IN_FRAME;
               end
            end
         endcase
      end
   endfunction

   function automatic void check_field(input string name, input logic [SUM_W-1:0] exp_v,
                                       input logic [SUM_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      res_type e;
      if (reset) begin
         len_limit = MAX_LEN_RESET;
         clear_frame();
         deframed_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            results++;
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected result, byte %0h last %0b status %0d sum %0h",
                        $time, out_byte, frame_last, frame_status, sum_value);
               fails++;
            end else begin
               e = deframed_q.pop_front();
               check_field("byte_valid", SUM_W'(e.byte_valid), SUM_W'(byte_valid));
               check_field("out_byte", SUM_W'(e.out_byte), SUM_W'(out_byte));
               check_field("frame_last", SUM_W'(e.frame_last), SUM_W'(frame_last));
               check_field("frame_status", SUM_W'(e.frame_status), SUM_W'(frame_status));
               check_field("sum_value", e.sum_value, sum_value);
               if (e.frame_last) begin
                  case (e.frame_status)
                     ST_GOOD:     goods++;
                     ST_BAD:      bads++;
                     ST_OVERFLOW: overflows++;
                     default:     timeouts++;
                  endcase
               end
            end
         end
         if (req_valid && req_ready) deframe_step(req_type, rx_byte);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == LEN_ADDR)
            len_limit = csr_pwdata[BYTE_W-1:0];
      end
      fail_count   <= fails;
      outstanding  <= deframed_q.size();
      results_seen <= results;
      n_good       <= goods;
      n_bad        <= bads;
      n_overflow   <= overflows;
      n_timeout    <= timeouts;
   end

endmodule

>>> tb/dle_frame_receiver_with_checksum_unit_tb.sv
`timescale 1ns / 1ps

module dle_frame_receiver_with_checksum_unit_tb;
   import dlefr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] LEN_ADDR = CSR_ADDR_W'(4 * CSR_IDX_MAX_FRAME_LEN);
   localparam logic REQ_BYTE    = ~REQ_TIMEOUT;
   localparam int   STALL_LIMIT = 4000;
   localparam int   HOLD_CYCLES = 300;
   localparam int   NUM_PHASES  = 10;
   localparam int   LONG_HOLD_PHASE = 6;
   // negative entry: pick a random limit
   localparam int   PHASE_LIMIT [NUM_PHASES] = '{255, 2, 0, 6, 1, 7, 40, -1, 255, 30};
   localparam logic [BYTE_W-1:0] DIRECTED [22] = '{
      DLE, DLE, STX, 8'h00, 8'hFF, DLE, DLE, DLE, 8'h55, 8'h01, 8'h32, DLE, ETX,
      DLE, 8'h07, DLE, STX, DLE, ETX, DLE, STX, 8'hAA};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count, outstanding, results_seen, n_good, n_bad, n_overflow, n_timeout;
   int sent_count = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int cur_limit = 30;
   bit rsp_hold = 1'b0;

   dlefr_req_if req_ch ();
   dlefr_rsp_if rsp_ch ();

   always #6 clock = ~clock;

   dle_frame_receiver_with_checksum_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   dlefr_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_type    (req_ch.req_type),
      .rx_byte     (req_ch.rx_byte),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .byte_valid  (rsp_ch.byte_valid),
      .out_byte    (rsp_ch.out_byte),
      .frame_last  (rsp_ch.frame_last),
      .frame_status(rsp_ch.frame_status),
      .sum_value   (rsp_ch.sum_value),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .results_seen(results_seen),
      .n_good      (n_good),
      .n_bad       (n_bad),
      .n_overflow  (n_overflow),
      .n_timeout   (n_timeout)
   );

   // send one request; bursts of random length with random gaps in between
   task automatic send_req(input logic rtype, input logic [BYTE_W-1:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 16);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= rtype;
      req_ch.rx_byte  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // hunting bytes produce nothing, so keep waiting after the expected results are all in
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [BYTE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LEN_ADDR;
      csr_pwdata  <= {(CSR_DATA_W - BYTE_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cur_limit = value;
   endtask

   function automatic logic [BYTE_W-1:0] pick_payload();
      return ($urandom_range(0, 5) == 0) ? DLE : BYTE_W'($urandom_range(0, 255));
   endfunction

   // a DLE inside the frame is followed by a stuffing byte that is never ETX
   task automatic send_data_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] stuff;
      send_req(REQ_BYTE, b);
      if (b == DLE) begin
         stuff = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(0, 255)) : DLE;
         if (stuff == ETX) stuff = DLE;
         send_req(REQ_BYTE, stuff);
      end
   endtask

   task automatic send_frame(input int plen, input bit corrupt);
      logic [SUM_W-1:0]  sum;
      logic [BYTE_W-1:0] b;
      sum = SUM_W'(DLE) + SUM_W'(STX);
      send_req(REQ_BYTE, DLE);
      send_req(REQ_BYTE, STX);
      repeat (plen) begin
         b = pick_payload();
         sum = sum + SUM_W'(b);
         send_data_byte(b);
      end
      if (corrupt) sum = sum ^ (SUM_W'(1) << $urandom_range(0, SUM_W - 1));
      send_data_byte(sum[15:8]);
      send_data_byte(sum[7:0]);
      send_req(REQ_BYTE, DLE);
      send_req(REQ_BYTE, ETX);
   endtask

   task automatic send_random_sequence();
      int pick, lim, plen, n;
      lim  = (cur_limit < 2) ? 2 : cur_limit;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         plen = 0;
         if (lim >= 6)
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lim - 6)
                                               : $urandom_range(0, (lim < 18) ? lim - 6 : 12);
         send_frame(plen, 1'b0);
      end else if (pick < 65) begin
         send_frame($urandom_range(0, 8), 1'b1);
      end else if (pick < 73) begin
         plen = lim - 5 + $urandom_range(0, 4);
         send_frame((plen < 0) ? 0 : plen, 1'b0);
      end else if (pick < 81) begin
         // frame cut short by a timeout
         send_req(REQ_BYTE, DLE);
         send_req(REQ_BYTE, STX);
         n = $urandom_range(0, 5);
         repeat (n) send_data_byte(pick_payload());
         send_req(REQ_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0:       send_req(REQ_BYTE, DLE);
               1:       send_req(REQ_BYTE, STX);
               2:       send_req(REQ_BYTE, ETX);
               default: send_req(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         send_req(REQ_TIMEOUT, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   // result side: stall patterns that change at random between four modes
   initial begin
      int mode, cyc;
      mode = 0;
      cyc  = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end else begin
            if (cyc % 48 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= (cyc % 4 == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
            cyc++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results still expected",
                  $time, STALL_LIMIT, outstanding);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int value, budget, phase_end;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= REQ_BYTE;
      req_ch.rx_byte  <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: timeout while hunting, repeated DLE before STX, stuffed DLE and
      // other stuffing, a frame with a bad checksum, DLE then junk, a short frame, timeout mid-frame
      send_req(REQ_TIMEOUT, 8'hFF);
      foreach (DIRECTED[i]) send_req(REQ_BYTE, DIRECTED[i]);
      send_req(REQ_TIMEOUT, 8'h00);

      // lower the limit below the count of an open frame
      send_req(REQ_BYTE, DLE);
      send_req(REQ_BYTE, STX);
      for (int i = 0; i < 8; i++) send_req(REQ_BYTE, BYTE_W'(8'h20 + i));
      wait_drained();
      csr_write(8'd4);
      send_req(REQ_BYTE, 8'h5A);
      wait_drained();
      // overflow on the opening STX
      csr_write(MIN_LEN);
      send_req(REQ_BYTE, DLE);
      send_req(REQ_BYTE, STX);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_drained();
         value = (PHASE_LIMIT[p] < 0) ? $urandom_range(2, 255) : PHASE_LIMIT[p];
         csr_write(BYTE_W'(value));
         budget = (value < 6) ? 60 : 190;
         // hold off the result side so the block backs up
         if (p == LONG_HOLD_PHASE) rsp_hold = 1'b1;
         phase_end = sent_count + budget;
         while (sent_count < phase_end) send_random_sequence();
      end

      wait_drained();
      $display("Sent %0d requests over %0d length limits, checked %0d results",
               sent_count, NUM_PHASES + 3, results_seen);
      $display("Frame ends: %0d good, %0d bad checksum, %0d overflow, %0d timeout",
               n_good, n_bad, n_overflow, n_timeout);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results never arrived", fail_count, outstanding);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
